// ===== src/esce_pkg.sv =====
// ----------------------------------------------------------------------------
// esce_pkg
// Types and constants shared by the serial EEPROM command engine.
// ----------------------------------------------------------------------------
package esce_pkg;

	// operation codes of a request item
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_ADDR,
		PH_DATA,
		PH_STOP,
		PH_SAMPLE
	} phase_t;

	localparam int unsigned ADDR_W      = 14;
	localparam int unsigned ADDR_SPAN_W = 16;   // widest address the line format allows
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned CFG_W       = 4;
	localparam int unsigned SKIP_BITS   = 4;    // dummy bits ahead of read data
	localparam int unsigned CMD_BITS    = 2;

	// register map
	localparam int unsigned PADDR_W          = 3;
	localparam logic        REG_ADDRESS_BITS = 1'b0;
	localparam logic [CFG_W-1:0] ADDRESS_BITS_RESET = 4'd14;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] write_data;
		logic              line_bit;
	} req_t;

	typedef struct packed {
		logic              drive_bit;
		logic              driving;
		logic [WORD_W-1:0] read_data;
		logic              done_res;
		logic              busy_res;
	} rsp_t;

endpackage

// ===== src/eeprom_serial_command_engine_top.sv =====
// ----------------------------------------------------------------------------
// eeprom_serial_command_engine_top
// Bit-serial command engine for a cartridge EEPROM with an APB register port.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t (operation, address, ...)
//   rsp      out        rsp_valid / rsp_ready  rsp_t (drive_bit, driving, ...)
//   apb      in/out     psel, penable, pready  address_bits register
//
// One item per cycle sustained while results are taken; each item's result is
// valid in the cycle after the edge that moves it out of the request register;
// an accepted item passes the request register, then the result register.
// The command sequencer steps once per item as it moves into the result
// register, so one item is one tick on the serial line.
// Reset puts the sequencer idle and address_bits to 14; no clearing pass.
// A stalled result holds the request register; req_ready drops only when
// both registers are full.
// ----------------------------------------------------------------------------
module eeprom_serial_command_engine_top import esce_pkg::*; #(
	parameter int unsigned MAX_ADDRESS_BITS = 14,
	parameter int unsigned DATA_BITS        = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [CFG_W-1:0] address_bits_val_q;
	logic             valid_s1;
	req_t             item_s1;
	logic             advance;
	rsp_t             result;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ADDRESS_BITS) ? {28'b0, address_bits_val_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_bits_val_q <= ADDRESS_BITS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_ADDRESS_BITS) begin
			address_bits_val_q <= pwdata[CFG_W-1:0];
		end
	end

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	esce_engine #(
		.MAX_ADDRESS_BITS(MAX_ADDRESS_BITS),
		.DATA_BITS       (DATA_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.address_bits(address_bits_val_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.done_res && rsp.busy_res))
		else $error("done and busy in the same result");

	a_read_data_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.done_res) |-> (rsp.read_data == '0))
		else $error("read data outside a done item");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid && !rsp_ready) |=> (valid_s1 && $stable(item_s1)))
		else $error("request stage lost an item under stall");

	a_cfg_write_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_ADDRESS_BITS)
		|=> (address_bits_val_q == $past(pwdata[CFG_W-1:0])))
		else $error("register write not taken");
`endif

endmodule

// ===== src/esce_engine.sv =====
// ----------------------------------------------------------------------------
// esce_engine
// Command sequencer: holds the command state and computes one line bit per
// step; the state advances only on step.
// ----------------------------------------------------------------------------
module esce_engine import esce_pkg::*; #(
	parameter int unsigned MAX_ADDRESS_BITS = 14,
	parameter int unsigned DATA_BITS        = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  req_t             item,
	input  logic [CFG_W-1:0] address_bits,
	output rsp_t             result
);

	localparam int unsigned LEN_W  = $clog2(MAX_ADDRESS_BITS + 1);
	localparam int unsigned SAMP_N = DATA_BITS + SKIP_BITS;
	localparam int unsigned CNT_A  = $clog2(SAMP_N + 1);
	localparam int unsigned CNT_W  = (CNT_A > LEN_W) ? CNT_A : LEN_W;

	phase_t                 phase_q, phase_d;
	logic [CNT_W-1:0]       bit_count_q, bit_count_d;
	logic [WORD_W-1:0]      shift_word_q, shift_word_d;
	logic [ADDR_SPAN_W-1:0] addr_latch_q, addr_latch_d;
	logic                   is_read_q, is_read_d;
	logic [LEN_W-1:0]       addr_len_q, addr_len_d;

	logic [LEN_W-1:0]  len_clamped;
	logic [CNT_W-1:0]  count_inc;
	logic [CNT_W-1:0]  addr_pos;
	logic [CNT_W-1:0]  samp_k;
	logic [5:0]        samp_idx;
	logic [WORD_W-1:0] sample_word;
	logic              is_start;

	always_comb begin
		if (address_bits == '0) begin
			len_clamped = LEN_W'(1);
		end else if ({1'b0, address_bits} > 5'(MAX_ADDRESS_BITS)) begin
			len_clamped = LEN_W'(MAX_ADDRESS_BITS);
		end else begin
			len_clamped = LEN_W'(address_bits);
		end
	end

	assign is_start  = (item.operation == OP_WRITE) || (item.operation == OP_READ);
	assign count_inc = bit_count_q + CNT_W'(1);
	assign addr_pos  = CNT_W'(addr_len_q) - CNT_W'(1) - bit_count_q;
	assign samp_k    = bit_count_q - CNT_W'(SKIP_BITS);
	assign samp_idx  = 6'(WORD_W - 1) - samp_k[5:0];

	// incoming bit merged into the word; dummy bits are dropped
	always_comb begin
		sample_word = shift_word_q;
		if (bit_count_q >= CNT_W'(SKIP_BITS)) begin
			sample_word[samp_idx] = item.line_bit;
		end
	end

	// next state
	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_word_d = shift_word_q;
		addr_latch_d = addr_latch_q;
		is_read_d    = is_read_q;
		addr_len_d   = addr_len_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_start) begin
					is_read_d    = (item.operation == OP_READ);
					addr_latch_d = ADDR_SPAN_W'(item.address);
					shift_word_d = (item.operation == OP_READ) ? '0 : item.write_data;
					addr_len_d   = len_clamped;
					bit_count_d  = '0;
					phase_d      = PH_CMD;
				end
			end
			PH_CMD: begin
				bit_count_d = count_inc;
				if (count_inc >= CNT_W'(CMD_BITS)) begin
					bit_count_d = '0;
					phase_d     = PH_ADDR;
				end
			end
			PH_ADDR: begin
				bit_count_d = count_inc;
				if (count_inc >= CNT_W'(addr_len_q)) begin
					bit_count_d = '0;
					phase_d     = is_read_q ? PH_STOP : PH_DATA;
				end
			end
			PH_DATA: begin
				shift_word_d = {shift_word_q[WORD_W-2:0], 1'b0};
				bit_count_d  = count_inc;
				if (count_inc >= CNT_W'(DATA_BITS)) begin
					bit_count_d = '0;
					phase_d     = PH_STOP;
				end
			end
			PH_STOP: begin
				bit_count_d = '0;
				if (is_read_q) begin
					shift_word_d = '0;
					phase_d      = PH_SAMPLE;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_SAMPLE: begin
				shift_word_d = sample_word;
				bit_count_d  = count_inc;
				if (count_inc >= CNT_W'(SAMP_N)) begin
					bit_count_d = '0;
					phase_d     = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		result           = '0;
		result.busy_res  = (phase_d != PH_IDLE);
		unique case (phase_q)
			PH_IDLE: begin
			end
			PH_CMD: begin
				result.driving   = 1'b1;
				result.drive_bit = (bit_count_q == '0) ? 1'b1 : is_read_q;
			end
			PH_ADDR: begin
				result.driving   = 1'b1;
				result.drive_bit = addr_latch_q[addr_pos[3:0]];
			end
			PH_DATA: begin
				result.driving   = 1'b1;
				result.drive_bit = shift_word_q[WORD_W-1];
			end
			PH_STOP: begin
				result.driving  = 1'b1;
				result.done_res = !is_read_q;
			end
			PH_SAMPLE: begin
				if (count_inc >= CNT_W'(SAMP_N)) begin
					result.done_res  = 1'b1;
					result.read_data = sample_word;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_word_q <= '0;
			addr_latch_q <= '0;
			is_read_q    <= 1'b0;
			addr_len_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_word_q <= shift_word_d;
			addr_latch_q <= addr_latch_d;
			is_read_q    <= is_read_d;
			addr_len_q   <= addr_len_d;
		end
	end

endmodule
